// ===== hdl/aff_pkg.sv =====
// Shared types, widths and constant tables for the affine 3x4 inverse block.
// Used by every module in the hdl folder; depends on nothing.
package aff_pkg;

	localparam int FRAC_BITS = 16;
	localparam int QW = 32;
	localparam int KW = 65;
	localparam int KMW = 64;
	localparam int SW = 97;
	localparam int SMW = 96;
	localparam int DAW = 96;
	localparam int DMW = DAW + 1;
	localparam int NUMW = (KMW + 2 * FRAC_BITS) > (SMW + FRAC_BITS) ?
		(KMW + 2 * FRAC_BITS) : (SMW + FRAC_BITS);
	localparam int NW = NUMW + 1;
	localparam int CMPW = NW > (DMW + QW) ? NW : (DMW + QW);
	localparam int TW = SW + FRAC_BITS;
	localparam int THW = 63;
	localparam int DIV_LAT = QW + 3;
	localparam int NPROD = 18;
	localparam int NCOF = 9;
	localparam int NKX = 12;
	localparam int NLANE = 4;

	localparam logic [1:0] ROW_LAST = 2'd2;
	localparam logic [QW-1:0] ONE_FX = QW'(64'd1 << FRAC_BITS);
	localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

	// Operand positions in the input row-major matrix for the cofactor products.
	// Cofactor n is product 2n minus product 2n+1.
	localparam int CF_A [NPROD] = '{5, 6, 2, 1, 1, 2, 6, 4, 0, 2, 2, 0, 4, 5, 1, 0, 0, 1};
	localparam int CF_B [NPROD] = '{10, 9, 9, 10, 6, 5, 8, 10, 10, 8, 4, 6, 9, 8, 8, 9, 5, 4};

	// Cofactor times matrix entry: three for the determinant, nine for the
	// rotated translation sums.
	localparam int MK_K [NKX] = '{0, 3, 6, 0, 1, 2, 3, 4, 5, 6, 7, 8};
	localparam int MK_X [NKX] = '{0, 1, 2, 3, 7, 11, 3, 7, 11, 3, 7, 11};

	typedef struct packed {
		logic [NCOF-1:0][KMW-1:0] kmag;
		logic [NCOF-1:0]          kneg;
		logic [2:0][SMW-1:0]      smag;
		logic [2:0]               sneg;
		logic [DAW-1:0]           dabs;
		logic                     dneg;
		logic                     sing;
	} fres_t;

	typedef struct packed {
		logic       v;
		logic [1:0] row;
		logic       sing;
		logic       last;
	} meta_t;

endpackage

// ===== hdl/aff_front.sv =====
// Item pipeline: cofactors, determinant, rotated translation and singular test.
// Six register stages; uses aff_pkg.
module aff_front import aff_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  m [12],
	input  logic [THW-1:0]      thr,
	output logic                out_valid,
	output fres_t               res
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [63:0]  p_s1 [NPROD];
	logic signed [31:0]  m_s1 [12];
	logic signed [31:0]  m_s2 [12];
	logic signed [KW-1:0] k_s2 [NCOF];
	logic signed [KW-1:0] k_s3 [NCOF];
	logic signed [KW-1:0] k_s4 [NCOF];
	logic signed [KW-1:0] k_s5 [NCOF];
	logic signed [64:0]  plo_s3 [NKX];
	logic signed [64:0]  phi_s3 [NKX];
	logic signed [SW-1:0] pp_s4 [NKX];
	logic signed [SW-1:0] det_s5;
	logic signed [SW-1:0] sum_s5 [3];
	fres_t res_s6;
	fres_t nxt;
	logic signed [63:0]  pr [NPROD];
	logic signed [KW-1:0] kv [NKX];
	logic [SW-1:0] neg_det;
	logic [SW-1:0] neg_sum [3];
	logic [KW-1:0] neg_k [NCOF];

	always_comb begin
		for (int n = 0; n < NPROD; n++) begin
			pr[n] = m[CF_A[n]] * m[CF_B[n]];
		end
		for (int i = 0; i < NKX; i++) begin
			kv[i] = k_s2[MK_K[i]];
		end
	end

	always_comb begin
		neg_det = -det_s5;
		nxt.dneg = det_s5[SW-1];
		nxt.dabs = det_s5[SW-1] ? neg_det[DAW-1:0] : det_s5[DAW-1:0];
		for (int n = 0; n < NCOF; n++) begin
			neg_k[n] = -k_s5[n];
			nxt.kneg[n] = k_s5[n][KW-1];
			nxt.kmag[n] = k_s5[n][KW-1] ? neg_k[n][KMW-1:0] : k_s5[n][KMW-1:0];
		end
		for (int r = 0; r < 3; r++) begin
			neg_sum[r] = -sum_s5[r];
			nxt.sneg[r] = sum_s5[r][SW-1];
			nxt.smag[r] = sum_s5[r][SW-1] ? neg_sum[r][SMW-1:0] : sum_s5[r][SMW-1:0];
		end
		nxt.sing = (nxt.dabs == '0) || (TW'(nxt.dabs) < (TW'(thr) << FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < NPROD; n++) begin
				p_s1[n] <= pr[n];
			end
			m_s1 <= m;
			m_s2 <= m_s1;
			for (int n = 0; n < NCOF; n++) begin
				k_s2[n] <= KW'(p_s1[2*n]) - KW'(p_s1[2*n+1]);
			end
			k_s3 <= k_s2;
			k_s4 <= k_s3;
			k_s5 <= k_s4;
			for (int i = 0; i < NKX; i++) begin
				plo_s3[i] <= $signed({1'b0, kv[i][31:0]}) * m_s2[MK_X[i]];
				phi_s3[i] <= $signed(kv[i][KW-1:32]) * m_s2[MK_X[i]];
				pp_s4[i] <= (SW'(phi_s3[i]) <<< 32) + SW'(plo_s3[i]);
			end
			det_s5 <= pp_s4[0] + pp_s4[1] + pp_s4[2];
			for (int r = 0; r < 3; r++) begin
				sum_s5[r] <= pp_s4[3+3*r] + pp_s4[4+3*r] + pp_s4[5+3*r];
			end
			res_s6 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_valid = v_s6;
	assign res = res_s6;

endmodule

// ===== hdl/aff_div_lane.sv =====
// One pipelined divider lane: rounded, saturated quotient of a magnitude by |det|.
// One quotient bit per stage; uses aff_pkg.
module aff_div_lane import aff_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic            neg,
	input  logic [DAW-1:0]  dabs,
	output logic [QW-1:0]   res
);

	logic [NW-1:0]  n_s1;
	logic [DMW-1:0] d_s1;
	logic           neg_s1;
	logic [NW-1:0]  rem_s [QW+1];
	logic [DMW-1:0] dd_s [QW+1];
	logic [QW-1:0]  q_s [QW+1];
	logic           ng_s [QW+1];
	logic           ov_s [QW+1];
	logic           ge [QW];
	logic [NW-1:0]  sub [QW];
	logic [QW-1:0]  res_q;
	logic [QW-1:0]  fin;
	logic [QW-1:0]  q_neg;

	always_comb begin
		for (int t = 0; t < QW; t++) begin
			ge[t] = CMPW'(rem_s[t]) >= (CMPW'(dd_s[t]) << (QW - 1 - t));
			sub[t] = rem_s[t] - NW'(CMPW'(dd_s[t]) << (QW - 1 - t));
		end
	end

	always_comb begin
		q_neg = -q_s[QW];
		if (ov_s[QW] || (q_s[QW] > SAT_NEG)) begin
			fin = ng_s[QW] ? SAT_NEG : SAT_POS;
		end else if (ng_s[QW]) begin
			fin = q_neg;
		end else if (q_s[QW][QW-1]) begin
			fin = SAT_POS;
		end else begin
			fin = q_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= {num, 1'b0} + NW'(dabs);
			d_s1 <= {dabs, 1'b0};
			neg_s1 <= neg;
			rem_s[0] <= n_s1;
			dd_s[0] <= d_s1;
			ng_s[0] <= neg_s1;
			q_s[0] <= '0;
			ov_s[0] <= CMPW'(n_s1) >= (CMPW'(d_s1) << QW);
			for (int t = 0; t < QW; t++) begin
				rem_s[t+1] <= ge[t] ? sub[t] : rem_s[t];
				q_s[t+1] <= q_s[t] | (QW'(ge[t]) << (QW - 1 - t));
				dd_s[t+1] <= dd_s[t];
				ng_s[t+1] <= ng_s[t];
				ov_s[t+1] <= ov_s[t];
			end
			res_q <= fin;
		end
	end

	assign res = res_q;

endmodule

// ===== hdl/affine_inverse_3x4.sv =====
// Top level of the affine 3x4 inverse: threshold register, row issue, divider lanes
// and output register. Depends on aff_pkg, aff_front and aff_div_lane.
//
// Usage: a matrix beat on s_* carries twelve signed Q16.16 entries in row-major
// order. The block answers with three beats on m_*, rows 0, 1 and 2 of the inverse,
// tlast on row 2. The cfg channel writes the 63-bit singular threshold; it is
// always ready and should be written only while the block is idle.
// Row 0 passes the front pipeline, the row issue register, the divider lanes and the
// output register; rows 1 and 2 follow it. The four divider lanes take one row per
// cycle while m_tready is not held low, so the row issue limits the matrix rate;
// under full load s_tready drops while the row issue still sends the last matrix.
// Reset clears every valid bit and sets the threshold to 1.
// When the receiver holds m_tready low, the divider lanes and output stage freeze,
// the beat holds, only front and row register fill; nothing is lost or repeated.
module affine_inverse_3x4 import aff_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [THW-1:0] cfg_data,
	input  logic           s_tvalid,
	output logic           s_tready,
	// row0_col0, row0_col1, row0_col2, row0_trans, row1_col0 .. row2_trans, 32 bits each
	input  logic [383:0]   s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// inv_col0, inv_col1, inv_col2, inv_trans, 32 bits each
	output logic [127:0]   m_tdata,
	// row_index (2 bits), singular
	output logic [2:0]     m_tuser,
	output logic           m_tlast
);

	logic [THW-1:0] thr_q;
	logic signed [31:0] m_in [12];
	logic ben, fen, fv, ser_free, ld;
	fres_t fres, ser_q;
	logic ser_v_q;
	logic [1:0] row_q;
	meta_t meta_s [DIV_LAT];
	meta_t meta_in;
	logic [NUMW-1:0] lane_num [NLANE];
	logic lane_neg [NLANE];
	logic [QW-1:0] lane_res [NLANE];
	logic [3:0] kidx [3];
	logic [QW-1:0] col_out [NLANE];
	logic out_v_q;
	logic [127:0] out_data_q;
	logic [2:0] out_user_q;
	logic out_last_q;

	always_comb begin
		for (int j = 0; j < 12; j++) begin
			m_in[j] = s_tdata[32*j +: 32];
		end
	end

	assign cfg_ready = 1'b1;
	assign ben = !out_v_q || m_tready;
	assign ser_free = !ser_v_q || (row_q == ROW_LAST && ben);
	assign ld = ser_free && fv;
	assign fen = !fv || ld;
	assign s_tready = fen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THW'(1);
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	aff_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fen),
		.in_valid  (s_tvalid),
		.m         (m_in),
		.thr       (thr_q),
		.out_valid (fv),
		.res       (fres)
	);

	always_ff @(posedge clk) begin
		if (ld) begin
			ser_q <= fres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			row_q <= '0;
		end else if (ld) begin
			ser_v_q <= 1'b1;
			row_q <= '0;
		end else if (ben && ser_v_q) begin
			if (row_q == ROW_LAST) begin
				ser_v_q <= 1'b0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			kidx[j] = 4'(row_q) * 4'd3 + 4'(j);
			lane_num[j] = NUMW'(ser_q.kmag[kidx[j]]) << (2 * FRAC_BITS);
			lane_neg[j] = ser_q.kneg[kidx[j]] ^ ser_q.dneg;
		end
		lane_num[3] = NUMW'(ser_q.smag[row_q]) << FRAC_BITS;
		lane_neg[3] = !ser_q.sneg[row_q] ^ ser_q.dneg;
		meta_in.v = ser_v_q;
		meta_in.row = row_q;
		meta_in.sing = ser_q.sing;
		meta_in.last = (row_q == ROW_LAST);
	end

	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		aff_div_lane u_lane (
			.clk  (clk),
			.en   (ben),
			.num  (lane_num[g]),
			.neg  (lane_neg[g]),
			.dabs (ser_q.dabs),
			.res  (lane_res[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < DIV_LAT; t++) begin
				meta_s[t] <= '0;
			end
		end else if (ben) begin
			meta_s[0] <= meta_in;
			for (int t = 1; t < DIV_LAT; t++) begin
				meta_s[t] <= meta_s[t-1];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NLANE; j++) begin
			if (meta_s[DIV_LAT-1].sing) begin
				col_out[j] = (j < 3 && meta_s[DIV_LAT-1].row == 2'(j)) ? ONE_FX : '0;
			end else begin
				col_out[j] = lane_res[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ben) begin
			out_v_q <= meta_s[DIV_LAT-1].v;
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			out_data_q <= {col_out[3], col_out[2], col_out[1], col_out[0]};
			out_user_q <= {meta_s[DIV_LAT-1].sing, meta_s[DIV_LAT-1].row};
			out_last_q <= meta_s[DIV_LAT-1].last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;
	assign m_tlast = out_last_q;

endmodule

// ===== hdl/aff_chk.sv =====
// Port-level checker for the affine 3x4 inverse, bound to the top level.
// Uses aff_pkg for the fixed-point one.
module aff_chk import aff_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [127:0]   m_tdata,
	input logic [2:0]     m_tuser,
	input logic           m_tlast
);

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[1:0] == ROW_LAST)))
		else $error("tlast does not match row 2");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] != 2'd3))
		else $error("row index out of range");

	a_ident_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2] && m_tuser[1:0] == 2'd0) |->
		(m_tdata[31:0] == ONE_FX && m_tdata[127:32] == '0))
		else $error("singular row 0 is not identity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output beat changed under stall");

endmodule

bind affine_inverse_3x4 aff_chk u_aff_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for affine_inverse_3x4: streams 3x4 fixed-point matrices,
// predicts the three inverse rows of each one and checks them beat by beat.
// Depends on aff_pkg and the affine_inverse_3x4 RTL.
`timescale 1ns / 1ps

module tb;
	import aff_pkg::*;

	typedef struct packed {
		logic [1:0]    row;
		logic [31:0]   c0;
		logic [31:0]   c1;
		logic [31:0]   c2;
		logic [31:0]   tr;
		logic          sing;
		logic          last;
	} inv_row_t;

	localparam int NDIR = 12;
	localparam int ONE = 65536;
	localparam int MAXV = 2147483647;
	localparam int MINV = -MAXV - 1;
	localparam int DIR_MAT [NDIR][12] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ONE, 0, 0, ONE, 0, ONE, 0, 2 * ONE, 0, 0, ONE, -3 * ONE},
		'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
		'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
		'{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0},
		'{1, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0},
		'{-1, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0},
		'{ONE, 0, 0, MINV, 0, ONE, 0, MINV, 0, 0, ONE, MINV},
		'{-ONE, 0, 0, MAXV, 0, -ONE, 0, MAXV, 0, 0, -ONE, MAXV},
		'{0, -ONE, 0, 5, ONE, 0, 0, -7, 0, 0, 2 * ONE, 9},
		'{MAXV, 0, 0, MINV, 0, MINV, 0, MAXV, 0, 0, MAXV, 0},
		'{ONE, ONE, 0, 0, ONE, ONE + 1, 0, 0, 0, 0, 1, 0}
	};
	// Rows whose determinant is zero or far below the reset threshold give identity.
	localparam bit DIR_IDENT [NDIR] = '{1, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};

	logic           clk = 0;
	logic           arst_n = 0;
	logic           cfg_valid = 0;
	logic           cfg_ready;
	logic [THW-1:0] cfg_data = '0;
	logic           s_tvalid = 0;
	logic           s_tready;
	logic [383:0]   s_tdata = '0;
	logic           m_tvalid;
	logic           m_tready = 0;
	logic [127:0]   m_tdata;
	logic [2:0]     m_tuser;
	logic           m_tlast;

	inv_row_t       pending_rows[$];
	logic [THW-1:0] threshold;
	int             errors = 0;
	int             matrices = 0;
	int             singular_seen = 0;
	int             rows_checked = 0;
	int             burst_left = 1;
	int             stall_cnt = 0;
	bit             stall_mode = 0;

	affine_inverse_3x4 u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic logic [31:0] round_div_sat(input logic signed [255:0] n,
		input logic signed [255:0] d);
		logic [255:0] nm;
		logic [255:0] dm;
		logic [255:0] q;
		logic         neg;
		neg = n[255] ^ d[255];
		nm = n[255] ? -n : n;
		dm = d[255] ? -d : d;
		q = ((nm << 1) + dm) / (dm << 1);
		if (q > 256'h8000_0000)
			return neg ? SAT_NEG : SAT_POS;
		if (neg)
			return 32'd0 - q[31:0];
		if (q > 256'h7fff_ffff)
			return SAT_POS;
		return q[31:0];
	endfunction

	function automatic void push_identity();
		inv_row_t r;
		for (int i = 0; i < 3; i++) begin
			r = '0;
			r.row = 2'(i);
			r.c0 = (i == 0) ? ONE_FX : '0;
			r.c1 = (i == 1) ? ONE_FX : '0;
			r.c2 = (i == 2) ? ONE_FX : '0;
			r.sing = 1'b1;
			r.last = (2'(i) == ROW_LAST);
			pending_rows = {pending_rows, r};
		end
	endfunction

	function automatic void predict_inverse(input logic [383:0] mat);
		logic signed [255:0] e [12];
		logic signed [255:0] k [3][3];
		logic signed [255:0] det;
		logic signed [255:0] tsum;
		logic [255:0]        dabs;
		logic [255:0]        lim;
		logic [31:0]         v [4];
		inv_row_t            r;
		for (int j = 0; j < 12; j++)
			e[j] = $signed(mat[j*32 +: 32]);
		k[0][0] = e[5] * e[10] - e[6] * e[9];
		k[0][1] = e[2] * e[9] - e[1] * e[10];
		k[0][2] = e[1] * e[6] - e[2] * e[5];
		k[1][0] = e[6] * e[8] - e[4] * e[10];
		k[1][1] = e[0] * e[10] - e[2] * e[8];
		k[1][2] = e[2] * e[4] - e[0] * e[6];
		k[2][0] = e[4] * e[9] - e[5] * e[8];
		k[2][1] = e[1] * e[8] - e[0] * e[9];
		k[2][2] = e[0] * e[5] - e[1] * e[4];
		det = k[0][0] * e[0] + k[1][0] * e[1] + k[2][0] * e[2];
		dabs = det[255] ? -det : det;
		lim = {193'd0, threshold} << FRAC_BITS;
		if (dabs == 0 || dabs < lim) begin
			push_identity();
			singular_seen++;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			tsum = 0;
			for (int j = 0; j < 3; j++) begin
				v[j] = round_div_sat(k[i][j] <<< (2 * FRAC_BITS), det);
				tsum = tsum + k[i][j] * e[j*4 + 3];
			end
			v[3] = round_div_sat((-tsum) <<< FRAC_BITS, det);
			r.row = 2'(i);
			r.c0 = v[0];
			r.c1 = v[1];
			r.c2 = v[2];
			r.tr = v[3];
			r.sing = 1'b0;
			r.last = (2'(i) == ROW_LAST);
			pending_rows = {pending_rows, r};
		end
	endfunction

	function automatic logic [383:0] random_matrix();
		logic [383:0] mat;
		int           mode;
		mode = $urandom_range(0, 9);
		for (int j = 0; j < 12; j++) begin
			if (mode <= 2 || j % 4 == 3)
				mat[j*32 +: 32] = $urandom;
			else
				mat[j*32 +: 32] = 32'($signed(32'($urandom_range(0, 262144))) - 131072);
		end
		if (mode >= 7) begin
			for (int j = 0; j < 3; j++)
				mat[(8+j)*32 +: 32] = mat[j*32 +: 32] + mat[(4+j)*32 +: 32]
					+ 32'($urandom_range(0, 2));
		end
		if (mode == 9)
			mat[$urandom_range(0, 11)*32 +: 32] = $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
		return mat;
	endfunction

	task automatic send_matrix(input logic [383:0] mat, input bit ident);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= mat;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (ident) begin
			push_identity();
			singular_seen++;
		end else begin
			predict_inverse(mat);
		end
		matrices++;
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_matrix(random_matrix(), 1'b0);
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		threshold = value;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 63)
			stall_mode <= ~stall_mode;
		m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	always @(posedge clk) begin
		inv_row_t got;
		inv_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tuser[1:0];
			got.c0 = m_tdata[31:0];
			got.c1 = m_tdata[63:32];
			got.c2 = m_tdata[95:64];
			got.tr = m_tdata[127:96];
			got.sing = m_tuser[2];
			got.last = m_tlast;
			if (pending_rows.size() == 0) begin
				errors++;
				$display("%t: unexpected output beat %h", $time, got);
			end else begin
				want = pending_rows.pop_front();
				rows_checked++;
				if (got != want) begin
					errors++;
					$display("%t: row mismatch expected row=%0d %h %h %h %h sing=%b last=%b",
						$time, want.row, want.c0, want.c1, want.c2, want.tr,
						want.sing, want.last);
					$display("%t:                actual row=%0d %h %h %h %h sing=%b last=%b",
						$time, got.row, got.c0, got.c1, got.c2, got.tr,
						got.sing, got.last);
				end
			end
		end
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [383:0] mat;
		threshold = 63'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < NDIR; n++) begin
			for (int j = 0; j < 12; j++)
				mat[j*32 +: 32] = DIR_MAT[n][j];
			send_matrix(mat, DIR_IDENT[n]);
		end
		send_random(20);

		write_threshold(63'd0);
		send_matrix('0, 1'b1);
		send_random(15);

		write_threshold({THW{1'b1}});
		send_random(15);

		write_threshold(63'd1 << 32);
		for (int j = 0; j < 12; j++)
			mat[j*32 +: 32] = DIR_MAT[1][j];
		send_matrix(mat, 1'b0);
		send_random(20);

		write_threshold(THW'({$urandom, $urandom} >> 1));
		send_random(12);
		write_threshold(63'($urandom_range(0, 1 << 20)));
		send_random(12);

		$display("Checked %0d inverse rows from %0d matrices, %0d of them singular.",
			rows_checked, matrices, singular_seen);
		$display("Thresholds covered zero, the reset value, the maximum and random values.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== affine_inverse_3x4.f =====
hdl/aff_pkg.sv
hdl/aff_front.sv
hdl/aff_div_lane.sv
hdl/affine_inverse_3x4.sv
hdl/aff_chk.sv
tb/tb.sv
